// File: design/mhc_pkg.sv
// ----------------------------------------------------------------------------
// mhc_pkg: shared types and constants of the MPC horizon cost block
// Item structs for both channels, register indexes, CORDIC and range
// reduction constants.
// ----------------------------------------------------------------------------
package mhc_pkg;

  // One horizon step as it arrives on the input channel.
  typedef struct packed {
    logic               is_first;
    logic               is_last;
    logic signed [31:0] init_x;
    logic signed [31:0] init_y;
    logic signed [31:0] init_heading;
    logic signed [31:0] ref_x;
    logic signed [31:0] ref_y;
    logic signed [31:0] ref_heading;
    logic signed [31:0] u_forward;
    logic signed [31:0] u_lateral;
    logic signed [31:0] u_yaw;
  } in_item_t;

  // The cost result of one horizon.
  typedef struct packed {
    logic signed [63:0] horizon_cost;
    logic               cost_saturated;
  } out_item_t;

  // Configuration register indexes.
  localparam int unsigned CFG_INDEX_W = 3;
  localparam logic [CFG_INDEX_W-1:0] CFG_WEIGHT_XX = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_WEIGHT_YY = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_WEIGHT_TT = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_WEIGHT_XY = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_WEIGHT_XT = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] CFG_WEIGHT_YT = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] CFG_STEP_TIME = 3'd6;

  // Register reset values.
  localparam logic [31:0] WEIGHT_DIAG_RESET = 32'd655360;
  localparam logic [31:0] WEIGHT_CROSS_RESET = 32'd0;
  localparam logic [31:0] STEP_TIME_RESET = 32'd8589935;

  // Angle constants in Q2.30.
  localparam logic [31:0] HALF_PI_Q30 = 32'd1686629713;
  localparam logic [31:0] QUARTER_PI_Q30 = 32'd843314856;
  localparam logic [31:0] CORDIC_GAIN_Q30 = 32'd652032874;
  localparam int unsigned CORDIC_ITERS = 24;

  // Quadrant search: the scaled heading is offset by 128 quarter turns plus
  // an eighth turn so that the quotient is a positive 8-bit number.
  localparam int unsigned QUAD_BITS = 8;
  localparam logic [39:0] REDUCE_BIAS = 40'd216731918120;

  // Arctangent of 2^-i in Q2.30.
  function automatic logic [31:0] atan_q30(input logic [4:0] i);
    logic [31:0] a;
    case (i)
      5'd0: a = 32'd843314856;
      5'd1: a = 32'd497837829;
      5'd2: a = 32'd263043836;
      5'd3: a = 32'd133525158;
      5'd4: a = 32'd67021686;
      5'd5: a = 32'd33543515;
      5'd6: a = 32'd16775850;
      5'd7: a = 32'd8388437;
      5'd8: a = 32'd4194282;
      5'd9: a = 32'd2097149;
      5'd10: a = 32'd1048575;
      5'd11: a = 32'd524287;
      5'd12: a = 32'd262143;
      5'd13: a = 32'd131071;
      5'd14: a = 32'd65535;
      5'd15: a = 32'd32767;
      5'd16: a = 32'd16383;
      5'd17: a = 32'd8191;
      5'd18: a = 32'd4095;
      5'd19: a = 32'd2047;
      5'd20: a = 32'd1023;
      5'd21: a = 32'd511;
      5'd22: a = 32'd255;
      5'd23: a = 32'd127;
      default: a = 32'd0;
    endcase
    return a;
  endfunction

endpackage

// File: design/mhc_cordic.sv
// ----------------------------------------------------------------------------
// mhc_cordic: iterative sine and cosine of a Q8.24 heading
// Reduces the heading by the nearest multiple of pi/2 with a reciprocal
// quotient estimate and one correction step, then runs rotation-mode CORDIC
// one iteration per cycle.
// ----------------------------------------------------------------------------
module mhc_cordic (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [31:0] heading,
  output logic               done,
  output logic signed [32:0] cos_val,
  output logic signed [32:0] sin_val
);

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_DIV  = 2'd1;
  localparam logic [1:0] PH_ROT  = 2'd2;
  localparam logic [1:0] PH_DONE = 2'd3;

  // Reciprocal of pi/2 for the top 15 bits of the biased angle: 2^10 / (pi/2).
  localparam logic [9:0] HALF_PI_RECIP = 10'd651;

  logic [1:0]         phase;
  logic [4:0]         cnt;
  logic [39:0]        rem;
  logic [23:0]        quo_prod;
  logic [mhc_pkg::QUAD_BITS-1:0] quo_est;
  logic [39:0]        rem_sub;
  logic               rem_over;
  logic [39:0]        rem_fix;
  logic [mhc_pkg::QUAD_BITS-1:0] quo;
  logic signed [33:0] x;
  logic signed [33:0] y;
  logic signed [33:0] z;
  logic signed [33:0] dx;
  logic signed [33:0] dy;
  logic signed [33:0] ang;

  // Quotient estimate from the top bits of the biased angle. The estimate is
  // never above the true quotient and at most one below it, so a single
  // compare and subtract finishes the reduction.
  always_comb begin
    quo_prod = 24'(rem[38:24]) * 24'(HALF_PI_RECIP);
    quo_est  = quo_prod[23:16];
    rem_sub  = rem - 40'(quo) * 40'(mhc_pkg::HALF_PI_Q30);
    rem_over = rem >= 40'(mhc_pkg::HALF_PI_Q30);
    rem_fix  = rem_over ? (rem - 40'(mhc_pkg::HALF_PI_Q30)) : rem;
  end

  // Shift-and-add terms of one CORDIC iteration; shifts floor.
  always_comb begin
    dx  = y >>> cnt;
    dy  = x >>> cnt;
    ang = $signed({2'b00, mhc_pkg::atan_q30(cnt)});
  end

  // Sequencer: three reduction steps, then rotation iterations.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
      cnt   <= '0;
    end else if (start) begin
      phase <= PH_DIV;
      cnt   <= 5'd2;
      rem   <= {{2{heading[31]}}, heading, 6'd0} + mhc_pkg::REDUCE_BIAS;
      quo   <= '0;
    end else begin
      case (phase)
        PH_DIV: begin
          if (cnt == 5'd2) begin
            quo <= quo_est;
            cnt <= 5'd1;
          end else if (cnt == 5'd1) begin
            rem <= rem_sub;
            cnt <= 5'd0;
          end else begin
            quo   <= quo + {{(mhc_pkg::QUAD_BITS-1){1'b0}}, rem_over};
            phase <= PH_ROT;
            z     <= $signed({2'b00, rem_fix[31:0]}) -
                     $signed({2'b00, mhc_pkg::QUARTER_PI_Q30});
            x     <= $signed({2'b00, mhc_pkg::CORDIC_GAIN_Q30});
            y     <= '0;
          end
        end
        PH_ROT: begin
          if (z >= 0) begin
            x <= x - dx;
            y <= y + dy;
            z <= z - ang;
          end else begin
            x <= x + dx;
            y <= y - dy;
            z <= z + ang;
          end
          if (cnt == 5'(mhc_pkg::CORDIC_ITERS - 1)) begin
            phase <= PH_DONE;
          end else begin
            cnt <= cnt + 5'd1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign done = (phase == PH_DONE);

  // Quadrant restore by swapping and negating.
  always_comb begin
    case (quo[1:0])
      2'd0: begin
        cos_val = 33'(x);
        sin_val = 33'(y);
      end
      2'd1: begin
        cos_val = 33'(-y);
        sin_val = 33'(x);
      end
      2'd2: begin
        cos_val = 33'(-x);
        sin_val = 33'(-y);
      end
      default: begin
        cos_val = 33'(y);
        sin_val = 33'(-x);
      end
    endcase
  end

endmodule

// File: design/mpc_horizon_cost_unicycle.sv
// ----------------------------------------------------------------------------
// mpc_horizon_cost_unicycle: quadratic MPC cost over a unicycle horizon
// Accumulates e'Qe per step and advances the pose by a forward Euler step,
// using one shared 33x33 multiplier under a small sequencer.
// ----------------------------------------------------------------------------
//  Channel   Handshake              Payload            Moves
//  in        in_valid / in_ready    in_item            one horizon step
//  out       out_valid / out_ready  out_item           cost of a horizon
//  cfg       cfg_write              cfg_index/cfg_data one register write
//
//  An item occupies the block from its acceptance through the errors, the
//  six cost terms (multiply, low half, high half and add each), the wait on
//  the CORDIC unit (its reduction and rotation are started with the errors),
//  the pose update and a finishing step. in_ready is high only
//  while the sequencer is idle.
//  Reset is synchronous; it restores the register defaults and zero state.
//  A result waiting on out_ready stalls only the end of the next last item.
// ----------------------------------------------------------------------------
module mpc_horizon_cost_unicycle (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  mhc_pkg::in_item_t                    in_item,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output mhc_pkg::out_item_t                   out_item,
  input  logic                                 cfg_write,
  input  logic [mhc_pkg::CFG_INDEX_W-1:0]      cfg_index,
  input  logic [31:0]                          cfg_data
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_ERR  = 4'd1;
  localparam logic [3:0] S_TMUL = 4'd2;
  localparam logic [3:0] S_TLO  = 4'd3;
  localparam logic [3:0] S_THI  = 4'd4;
  localparam logic [3:0] S_TADD = 4'd5;
  localparam logic [3:0] S_WAIT = 4'd6;
  localparam logic [3:0] S_VA   = 4'd7;
  localparam logic [3:0] S_VB   = 4'd8;
  localparam logic [3:0] S_VLO  = 4'd9;
  localparam logic [3:0] S_VHI  = 4'd10;
  localparam logic [3:0] S_VADD = 4'd11;
  localparam logic [3:0] S_HMUL = 4'd12;
  localparam logic [3:0] S_HADD = 4'd13;
  localparam logic [3:0] S_DONE = 4'd14;

  logic [3:0] state;
  logic [2:0] term;
  logic       axis;

  // Configuration registers.
  logic signed [31:0] weight_xx, weight_yy, weight_tt;
  logic signed [31:0] weight_xy, weight_xt, weight_yt;
  logic [31:0]        step_time;

  // Block state.
  logic signed [31:0] pose_x, pose_y, pose_heading;
  logic signed [31:0] ref_x_held, ref_y_held, ref_heading_held;
  logic signed [63:0] cost;
  logic               sat_seen;

  // Per-item working registers.
  logic signed [31:0] u_forward, u_lateral, u_yaw;
  logic               last_item;
  logic signed [31:0] err_x, err_y, err_t;
  logic signed [63:0] wide_op;
  logic signed [96:0] acc;

  logic               cordic_start;
  logic               cordic_done;
  logic signed [32:0] cos_val, sin_val;
  logic               out_load;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      weight_xx <= mhc_pkg::WEIGHT_DIAG_RESET;
      weight_yy <= mhc_pkg::WEIGHT_DIAG_RESET;
      weight_tt <= mhc_pkg::WEIGHT_DIAG_RESET;
      weight_xy <= mhc_pkg::WEIGHT_CROSS_RESET;
      weight_xt <= mhc_pkg::WEIGHT_CROSS_RESET;
      weight_yt <= mhc_pkg::WEIGHT_CROSS_RESET;
      step_time <= mhc_pkg::STEP_TIME_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        mhc_pkg::CFG_WEIGHT_XX: weight_xx <= cfg_data;
        mhc_pkg::CFG_WEIGHT_YY: weight_yy <= cfg_data;
        mhc_pkg::CFG_WEIGHT_TT: weight_tt <= cfg_data;
        mhc_pkg::CFG_WEIGHT_XY: weight_xy <= cfg_data;
        mhc_pkg::CFG_WEIGHT_XT: weight_xt <= cfg_data;
        mhc_pkg::CFG_WEIGHT_YT: weight_yt <= cfg_data;
        mhc_pkg::CFG_STEP_TIME: step_time <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Pose errors, each clipped to Q8.24.
  logic signed [32:0] dif_x, dif_y, dif_t;
  logic clip_x, clip_y, clip_t;
  always_comb begin
    dif_x  = {pose_x[31], pose_x} - {ref_x_held[31], ref_x_held};
    dif_y  = {pose_y[31], pose_y} - {ref_y_held[31], ref_y_held};
    dif_t  = {pose_heading[31], pose_heading} -
             {ref_heading_held[31], ref_heading_held};
    clip_x = dif_x[32] != dif_x[31];
    clip_y = dif_y[32] != dif_y[31];
    clip_t = dif_t[32] != dif_t[31];
  end

  function automatic logic signed [31:0] clip32(input logic signed [32:0] v);
    logic signed [31:0] r;
    if (v[32] != v[31]) begin
      r = v[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // Operands of the current cost term.
  logic signed [31:0] term_a, term_b, term_w;
  always_comb begin
    case (term)
      3'd0: begin term_a = err_x; term_b = err_x; term_w = weight_xx; end
      3'd1: begin term_a = err_y; term_b = err_y; term_w = weight_yy; end
      3'd2: begin term_a = err_t; term_b = err_t; term_w = weight_tt; end
      3'd3: begin term_a = err_x; term_b = err_y; term_w = weight_xy; end
      3'd4: begin term_a = err_x; term_b = err_t; term_w = weight_xt; end
      default: begin term_a = err_y; term_b = err_t; term_w = weight_yt; end
    endcase
  end

  // Shared multiplier and its operand selection.
  logic signed [32:0] mul_a, mul_b, scale;
  logic signed [65:0] prod;
  always_comb begin
    scale = (state == S_VLO || state == S_VHI) ? $signed({1'b0, step_time})
                                               : {term_w[31], term_w};
    case (state)
      S_TMUL: begin
        mul_a = {term_a[31], term_a};
        mul_b = {term_b[31], term_b};
      end
      S_TLO, S_VLO: begin
        mul_a = $signed({1'b0, wide_op[31:0]});
        mul_b = scale;
      end
      S_THI, S_VHI: begin
        mul_a = {wide_op[63], wide_op[63:32]};
        mul_b = scale;
      end
      S_VA: begin
        mul_a = axis ? sin_val : cos_val;
        mul_b = {u_forward[31], u_forward};
      end
      S_VB: begin
        mul_a = axis ? cos_val : sin_val;
        mul_b = {u_lateral[31], u_lateral};
      end
      S_HMUL: begin
        mul_a = {u_yaw[31], u_yaw};
        mul_b = $signed({1'b0, step_time});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    prod = mul_a * mul_b;
  end

  // Floor shift of the wide product and clamp to 64 bits.
  logic signed [96:0] shifted;
  logic signed [63:0] scaled;
  logic               scaled_clip;
  always_comb begin
    shifted     = (state == S_VADD) ? (acc >>> 62) : (acc >>> 32);
    scaled_clip = shifted[96:63] != {34{shifted[63]}};
    if (scaled_clip) begin
      scaled = shifted[96] ? 64'sh8000_0000_0000_0000 : 64'sh7fff_ffff_ffff_ffff;
    end else begin
      scaled = shifted[63:0];
    end
  end

  // Saturating cost add.
  logic signed [64:0] cost_sum;
  logic signed [63:0] cost_new;
  logic               cost_clip;
  always_comb begin
    cost_sum  = {cost[63], cost} + {scaled[63], scaled};
    cost_clip = cost_sum[64] != cost_sum[63];
    if (cost_clip) begin
      cost_new = cost_sum[64] ? 64'sh8000_0000_0000_0000 : 64'sh7fff_ffff_ffff_ffff;
    end else begin
      cost_new = cost_sum[63:0];
    end
  end

  // Saturating pose update.
  logic signed [31:0] pose_base;
  logic signed [64:0] pose_sum;
  logic signed [31:0] pose_new;
  logic               pose_clip;
  always_comb begin
    if (state == S_HADD) begin
      pose_base = pose_heading;
    end else begin
      pose_base = axis ? pose_y : pose_x;
    end
    pose_sum  = {{33{pose_base[31]}}, pose_base} + {scaled[63], scaled};
    pose_clip = pose_sum[64:31] != {34{pose_sum[31]}};
    if (pose_clip) begin
      pose_new = pose_sum[64] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    end else begin
      pose_new = pose_sum[31:0];
    end
  end

  assign in_ready     = (state == S_IDLE);
  assign cordic_start = (state == S_ERR);

  // A finished last item loads the output register once it is free.
  assign out_load = (state == S_DONE) && last_item && (!out_valid || out_ready);

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_IDLE;
      term             <= '0;
      axis             <= 1'b0;
      pose_x           <= '0;
      pose_y           <= '0;
      pose_heading     <= '0;
      ref_x_held       <= '0;
      ref_y_held       <= '0;
      ref_heading_held <= '0;
      cost             <= '0;
      sat_seen         <= 1'b0;
      out_valid        <= 1'b0;
    end else begin
      if (out_valid && out_ready && !out_load) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            u_forward <= in_item.u_forward;
            u_lateral <= in_item.u_lateral;
            u_yaw     <= in_item.u_yaw;
            last_item <= in_item.is_last;
            if (in_item.is_first) begin
              pose_x           <= in_item.init_x;
              pose_y           <= in_item.init_y;
              pose_heading     <= in_item.init_heading;
              ref_x_held       <= in_item.ref_x;
              ref_y_held       <= in_item.ref_y;
              ref_heading_held <= in_item.ref_heading;
              cost             <= '0;
              sat_seen         <= 1'b0;
            end
            state <= S_ERR;
          end
        end
        S_ERR: begin
          err_x <= clip32(dif_x);
          err_y <= clip32(dif_y);
          err_t <= clip32(dif_t);
          if (clip_x || clip_y || clip_t) begin
            sat_seen <= 1'b1;
          end
          term  <= '0;
          state <= S_TMUL;
        end
        S_TMUL: begin
          wide_op <= prod[63:0];
          state   <= S_TLO;
        end
        S_TLO, S_VLO: begin
          acc   <= 97'(prod);
          state <= (state == S_TLO) ? S_THI : S_VHI;
        end
        S_THI, S_VHI: begin
          acc   <= acc + (97'(prod) <<< 32);
          state <= (state == S_THI) ? S_TADD : S_VADD;
        end
        S_TADD: begin
          cost <= cost_new;
          if (scaled_clip || cost_clip) begin
            sat_seen <= 1'b1;
          end
          if (term == 3'd5) begin
            state <= S_WAIT;
          end else begin
            term  <= term + 3'd1;
            state <= S_TMUL;
          end
        end
        S_WAIT: begin
          if (cordic_done) begin
            axis  <= 1'b0;
            state <= S_VA;
          end
        end
        S_VA: begin
          wide_op <= prod[63:0];
          state   <= S_VB;
        end
        S_VB: begin
          wide_op <= axis ? (wide_op + prod[63:0]) : (wide_op - prod[63:0]);
          state   <= S_VLO;
        end
        S_VADD: begin
          if (axis) begin
            pose_y <= pose_new;
          end else begin
            pose_x <= pose_new;
          end
          if (scaled_clip || pose_clip) begin
            sat_seen <= 1'b1;
          end
          if (axis) begin
            state <= S_HMUL;
          end else begin
            axis  <= 1'b1;
            state <= S_VA;
          end
        end
        S_HMUL: begin
          acc   <= 97'(prod);
          state <= S_HADD;
        end
        S_HADD: begin
          pose_heading <= pose_new;
          if (scaled_clip || pose_clip) begin
            sat_seen <= 1'b1;
          end
          state <= S_DONE;
        end
        S_DONE: begin
          if (!last_item) begin
            state <= S_IDLE;
          end else if (out_load) begin
            out_item.horizon_cost   <= cost;
            out_item.cost_saturated <= sat_seen;
            out_valid               <= 1'b1;
            state                   <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  mhc_cordic u_cordic (
    .clk     (clk),
    .rst     (rst),
    .start   (cordic_start),
    .heading (pose_heading),
    .done    (cordic_done),
    .cos_val (cos_val),
    .sin_val (sin_val)
  );

  // Only one item is in work at a time.
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("new item taken while one is in work");

  // The pose update never starts before sine and cosine are ready.
  a_cordic_ready: assert property (@(posedge clk) disable iff (rst)
    (state == S_VA) |-> cordic_done)
    else $error("pose update started without CORDIC result");

  // A result appears only at the end of an item marked last.
  a_out_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == S_DONE) && last_item)
    else $error("result raised outside the end of a last item");

endmodule
